// ===== hw/rtl/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// Types and constants shared by the indexed doubly linked list core.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

  localparam int unsigned NODES = 1024;
  localparam int unsigned ID_W  = $clog2(NODES);
  localparam int unsigned CNT_W = ID_W + 1;

  localparam logic [ID_W-1:0]  ID_NONE  = '0;
  localparam logic [ID_W-1:0]  ID_FIRST = ID_W'(1);
  localparam logic [CNT_W-1:0] ID_START = CNT_W'(2);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } idll_req_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_REMOVED = 3'd1,
    STAT_ABSENT  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_EMPTY   = 3'd4
  } idll_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } idll_state_e;

  typedef struct packed {
    idll_req_e       req_type;
    logic [ID_W-1:0] target_id;
    logic            side;
  } idll_req_t;

  typedef struct packed {
    logic [ID_W-1:0] node_id;
    idll_status_e    status;
    logic            last;
  } idll_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/idll_ram.sv =====
// ----------------------------------------------------------------------------
// idll_ram
// Simple dual-port synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_doubly_linked_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_core
// Ordered list of node ids kept in prev and next link memories addressed by id.
// ----------------------------------------------------------------------------
//  Port     | Dir | Beat rule
//  ---------+-----+---------------------------------------------------------
//  req_i    | in  | taken on a rising edge with start high and busy low
//  res_o    | out | valid for the single cycle in which done_o is high
//
//  A read-next, an unused request or a failed request raises done_o from the
//  execute state; a successful insert or remove raises it from the finish
//  state, which makes the second write to the link memories. The next
//  request may be accepted while the previous result is shown.
//  No clearing pass is needed after reset: the issued-id counter marks the
//  ids that hold data, so the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire idll_pkg::idll_req_t req_i,
  output logic                    done_o,
  output idll_pkg::idll_res_t     res_o
);
  import idll_pkg::*;

  idll_state_e state_q, state_d;

  logic [ID_W-1:0]  head_q, head_d;
  logic [ID_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0] nnid_q, nnid_d;
  logic [ID_W-1:0]  cursor_q, cursor_d;
  logic             p1w_q, p1w_d;
  logic             n1w_q, n1w_d;
  logic             done_q, done_d;

  idll_req_t        req_q, req_d;
  logic [ID_W-1:0]  rd_addr_q, rd_addr_d;
  logic [ID_W-1:0]  aux_q, aux_d;
  idll_res_t        res_q, res_d;

  // Prev memory words carry a removed flag above the link.
  logic              prev_we, next_we, rd_en;
  logic [ID_W-1:0]   prev_waddr, next_waddr;
  logic [ID_W:0]     prev_wdata;
  logic [ID_W-1:0]   next_wdata;
  logic [ID_W:0]     prev_raw, prev_ent;
  logic [ID_W-1:0]   next_raw, next_id, prev_id;
  logic              gone;

  logic              accept;
  logic [ID_W-1:0]   cur_id;
  logic [ID_W-1:0]   new_id;
  logic              tgt_assigned, tgt_present, full, exec_long;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign cur_id = (cursor_q != ID_NONE) ? cursor_q : head_q;
  assign new_id = nnid_q[ID_W-1:0];

  idll_ram #(.WIDTH(ID_W + 1), .DEPTH(NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (rd_en),
    .raddr_i (req_i.target_id),
    .rdata_o (prev_raw)
  );

  idll_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr_d),
    .rdata_o (next_raw)
  );

  // Node 1 exists from reset with empty links; until its entries are first
  // written, reads of them return zero.
  assign prev_ent = (req_q.target_id == ID_FIRST && !p1w_q) ? '0 : prev_raw;
  assign next_id  = (rd_addr_q == ID_FIRST && !n1w_q) ? ID_NONE : next_raw;
  assign prev_id  = prev_ent[ID_W-1:0];
  assign gone     = prev_ent[ID_W];

  assign tgt_assigned = (req_q.target_id != ID_NONE) &&
                        ({1'b0, req_q.target_id} < nnid_q);
  assign tgt_present  = tgt_assigned && !gone;
  assign full         = (nnid_q >= CNT_W'(NODES));
  assign exec_long    = ((req_q.req_type == REQ_INSERT) && tgt_present && !full) ||
                        ((req_q.req_type == REQ_REMOVE) && tgt_present);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = exec_long ? S_FIN : S_IDLE;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    nnid_d     = nnid_q;
    cursor_d   = cursor_q;
    done_d     = 1'b0;
    req_d      = req_q;
    rd_addr_d  = rd_addr_q;
    aux_d      = aux_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    prev_we    = 1'b0;
    prev_waddr = req_q.target_id;
    prev_wdata = '0;
    next_we    = 1'b0;
    next_waddr = req_q.target_id;
    next_wdata = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d     = req_i;
          rd_en     = 1'b1;
          rd_addr_d = (req_i.req_type == REQ_READ) ? cur_id : req_i.target_id;
        end
      end

      S_EXEC: begin
        case (req_q.req_type)
          REQ_INSERT: begin
            if (!tgt_present || full) begin
              done_d = 1'b1;
              res_d  = '{node_id: ID_NONE,
                         status: tgt_present ? STAT_FULL : STAT_ABSENT,
                         last: 1'b0};
            end else if (!req_q.side) begin
              aux_d      = prev_id;
              prev_we    = 1'b1;
              prev_waddr = req_q.target_id;
              prev_wdata = {1'b0, new_id};
              next_we    = 1'b1;
              next_waddr = new_id;
              next_wdata = req_q.target_id;
            end else begin
              aux_d      = next_id;
              next_we    = 1'b1;
              next_waddr = req_q.target_id;
              next_wdata = new_id;
              prev_we    = 1'b1;
              prev_waddr = new_id;
              prev_wdata = {1'b0, req_q.target_id};
            end
          end

          REQ_REMOVE: begin
            if (!tgt_present) begin
              done_d = 1'b1;
              res_d  = '{node_id: ID_NONE,
                         status: tgt_assigned ? STAT_REMOVED : STAT_ABSENT,
                         last: 1'b0};
            end else begin
              aux_d = prev_id;
              if (prev_id == ID_NONE) begin
                head_d = next_id;
              end else begin
                next_we    = 1'b1;
                next_waddr = prev_id;
                next_wdata = next_id;
              end
              if (next_id == ID_NONE) begin
                tail_d = prev_id;
              end else begin
                prev_we    = 1'b1;
                prev_waddr = next_id;
                prev_wdata = {1'b0, prev_id};
              end
              if (cursor_q == req_q.target_id) begin
                cursor_d = next_id;
              end
            end
          end

          REQ_READ: begin
            done_d = 1'b1;
            if (head_q == ID_NONE) begin
              cursor_d = ID_NONE;
              res_d    = '{node_id: ID_NONE, status: STAT_EMPTY, last: 1'b0};
            end else begin
              cursor_d = next_id;
              res_d    = '{node_id: rd_addr_q, status: STAT_OK,
                           last: (next_id == ID_NONE)};
            end
          end

          default: begin
            done_d = 1'b1;
            res_d  = '{node_id: ID_NONE, status: STAT_OK, last: 1'b0};
          end
        endcase
      end

      S_FIN: begin
        done_d = 1'b1;
        if (req_q.req_type == REQ_INSERT) begin
          nnid_d = nnid_q + CNT_W'(1);
          res_d  = '{node_id: new_id, status: STAT_OK, last: 1'b0};
          if (!req_q.side) begin
            prev_we    = 1'b1;
            prev_waddr = new_id;
            prev_wdata = {1'b0, aux_q};
            if (aux_q == ID_NONE) begin
              head_d = new_id;
            end else begin
              next_we    = 1'b1;
              next_waddr = aux_q;
              next_wdata = new_id;
            end
          end else begin
            next_we    = 1'b1;
            next_waddr = new_id;
            next_wdata = aux_q;
            if (aux_q == ID_NONE) begin
              tail_d = new_id;
            end else begin
              prev_we    = 1'b1;
              prev_waddr = aux_q;
              prev_wdata = {1'b0, new_id};
            end
          end
        end else begin
          // Mark the removed node; its prev link is kept as it was.
          res_d      = '{node_id: ID_NONE, status: STAT_OK, last: 1'b0};
          prev_we    = 1'b1;
          prev_waddr = req_q.target_id;
          prev_wdata = {1'b1, aux_q};
        end
      end

      default: ;
    endcase
  end

  assign p1w_d = p1w_q || (prev_we && prev_waddr == ID_FIRST);
  assign n1w_d = n1w_q || (next_we && next_waddr == ID_FIRST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= ID_FIRST;
      tail_q   <= ID_FIRST;
      nnid_q   <= ID_START;
      cursor_q <= ID_NONE;
      p1w_q    <= 1'b0;
      n1w_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      nnid_q   <= nnid_d;
      cursor_q <= cursor_d;
      p1w_q    <= p1w_d;
      n1w_q    <= n1w_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rd_addr_q <= rd_addr_d;
    aux_q     <= aux_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/idll_checker.sv =====
// ----------------------------------------------------------------------------
// idll_checker
// Port-level checks on request acceptance and result beats of the list core.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done_o,
  input wire idll_pkg::idll_res_t res_o
);
  import idll_pkg::*;

  // An accepted request keeps the core busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a request");

  // A result beat never appears right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result beat one cycle after accept");

  // Results are shown only once the core is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while core busy");

  // A failed request carries no id and no tail flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != STAT_OK) |-> (res_o.node_id == '0 && !res_o.last))
    else $error("failed request returned an id or tail flag");

  // The tail flag only comes with a successful read of a real node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.last) |-> (res_o.status == STAT_OK && res_o.node_id != '0))
    else $error("tail flag on an invalid result");

endmodule

bind indexed_doubly_linked_list_core idll_checker u_idll_checker (.*);

`default_nettype wire
